// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Asserts that an antecedent implies a consequent at the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mjs_pkg.sv -----
// Package with the types, constants and ranking helper of the job scheduler.
package mjs_pkg;

  localparam int NumCores   = 8;
  localparam int QueueDepth = 32;
  localparam int CoreW      = $clog2(NumCores);
  localparam int QIdxW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);
  localparam int ActW       = 4;
  localparam logic [47:0] SumMax = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ActArrive  = 2'd0,
    ActFinish  = 2'd1,
    ActQuantum = 2'd2,
    ActNone    = 2'd3
  } action_e;

  localparam logic [2:0] SchFcfs  = 3'd0;
  localparam logic [2:0] SchSjf   = 3'd1;
  localparam logic [2:0] SchPsjf  = 3'd2;
  localparam logic [2:0] SchPrio  = 3'd3;
  localparam logic [2:0] SchPprio = 3'd4;
  localparam logic [2:0] SchRr    = 3'd5;

  localparam logic [0:0] RegScheme = 1'd0;
  localparam logic [0:0] RegCores  = 1'd1;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [31:0] arrival;
    logic [31:0] start;
    logic        started;
    logic [31:0] remain;
    logic [15:0] length;
  } job_t;

  typedef enum logic [3:0] {
    StIdle,
    StCount,
    StDispatch,
    StVictim,
    StInsRead,
    StInsScan,
    StShRead,
    StShWrite,
    StInsWrite,
    StStats,
    StDeqRead,
    StDeqHead,
    StDnRead,
    StDnWrite,
    StDone
  } state_e;

  // Strict ranking of a before b under the given scheme.
  function automatic logic ranks_before(logic [2:0] sch, job_t a, job_t b);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = a.arrival;
    kb = b.arrival;
    if (sch == SchSjf || sch == SchPsjf) begin
      ka = a.remain;
      kb = b.remain;
    end else if (sch == SchPrio || sch == SchPprio) begin
      ka = {24'd0, a.prio};
      kb = {24'd0, b.prio};
    end
    if (sch == SchRr) begin
      return 1'b0;
    end
    if (ka != kb) begin
      return ka < kb;
    end
    return a.arrival < b.arrival;
  endfunction

endpackage

// ----- hw/rtl/multicore_job_scheduler_core.sv -----
// The remaining time of each active core is counted down, one core per cycle, before
// dispatch; queue moves read and then write each entry in the single-port RAM.
// Throughput: one event at a time; busy drops as the strobe appears, so the next
// request is taken at the edge that ends the strobe. Reset clears cores, queue count,
// time, totals and configuration; queue and core records are not cleared.
// Top level of the multicore job scheduler: sequencer, cores and queue.
module multicore_job_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [15:0] job_id_i,
  input  logic [31:0] event_time_i,
  input  logic [15:0] run_length_i,
  input  logic [7:0]  job_priority_i,
  input  logic [2:0]  core_sel_i,
  output logic        done_o,
  output logic        assigned_o,
  output logic [2:0]  core_out_o,
  output logic [15:0] job_out_o,
  output logic        queue_overflow_o,
  output logic [47:0] wait_total_o,
  output logic [47:0] turnaround_total_o,
  output logic [47:0] response_total_o,
  output logic [31:0] jobs_done_o
);
  import mjs_pkg::*;

  localparam int JobW = $bits(job_t);

  state_e state_q, state_d;
  logic [2:0] scheme_q;
  logic [ActW-1:0] cores_q;
  logic [NumCores-1:0] busy_q, busy_d;
  job_t core_job_q [NumCores];
  logic core_we;
  logic [CoreW-1:0] core_wa;
  job_t core_wd;

  logic [1:0]  act_q;
  logic [31:0] t_q, last_q, delta_q;
  logic        back_q;
  logic [CoreW-1:0] csel_q;
  job_t nj_q, nj_d, hold_q, hold_d;
  logic [QCntW-1:0] qcnt_q, qcnt_d;
  logic [QCntW-1:0] pos_q, pos_d;
  logic [QCntW-1:0] slot_q, slot_d;
  logic [CoreW:0] ci_q, ci_d;
  logic [CoreW-1:0] tgt_q, tgt_d;
  logic vic_q, vic_d;
  logic [1:0] st_q, st_d;
  logic assigned_q, assigned_d, ovf_q, ovf_d;
  logic [CoreW-1:0] cout_q, cout_d;
  logic [15:0] jout_q, jout_d;
  logic done_q;

  logic ram_we;
  logic [QIdxW-1:0] ram_a;
  job_t ram_wd, ram_rd;

  logic [CoreW:0] ncores;
  logic cfg_wr;
  logic idle_found;
  logic [CoreW-1:0] idle_core;
  logic csel_ok;
  logic last_core;
  logic head_loses;
  job_t cj;
  logic [33:0] term;
  logic stat_en;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegCores) ? {28'd0, cores_q} : {29'd0, scheme_q};

  always_comb begin
    if (cores_q == '0) begin
      ncores = (CoreW + 1)'(1);
    end else if (cores_q > ActW'(NumCores)) begin
      ncores = (CoreW + 1)'(NumCores);
    end else begin
      ncores = cores_q[CoreW:0];
    end
  end

  always_comb begin
    idle_found = 1'b0;
    idle_core = '0;
    for (int i = NumCores - 1; i >= 0; i--) begin
      if (!busy_q[i] && (CoreW + 1)'(i) < ncores) begin
        idle_found = 1'b1;
        idle_core = CoreW'(i);
      end
    end
  end

  assign csel_ok = ({1'b0, csel_q} < ncores) && busy_q[csel_q];
  assign cj = core_job_q[ci_q[CoreW-1:0]];
  assign last_core = (ci_q + 1'b1 >= ncores);
  // On a quantum event the running job keeps its core if it strictly beats the head.
  assign head_loses = (act_q == ActQuantum) &&
                      ranks_before(scheme_q, core_job_q[csel_q], ram_rd);

  mjs_ram #(.Width(JobW), .Depth(QueueDepth)) u_queue (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_a),
    .wdata_i(ram_wd),
    .rdata_o(ram_rd)
  );

  mjs_stats u_stats (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (stat_en),
    .sel_i (st_q),
    .term_i(term),
    .wait_o(wait_total_o),
    .turn_o(turnaround_total_o),
    .resp_o(response_total_o),
    .done_o(jobs_done_o)
  );

  // Statistic terms for the finishing job on csel.
  always_comb begin
    job_t fj;
    fj = core_job_q[csel_q];
    case (st_q)
      2'd0: term = {2'b0, t_q} - {2'b0, fj.arrival} - {18'd0, fj.length};
      2'd1: term = {2'b0, t_q} - {2'b0, fj.arrival};
      2'd2: term = {2'b0, fj.start} - {2'b0, fj.arrival};
      default: term = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (start) state_d = StCount;
      StCount: if (last_core) state_d = StDispatch;
      StDispatch: begin
        case (act_q)
          ActArrive: begin
            if (idle_found) begin
              state_d = StDone;
            end else if (scheme_q == SchPsjf || scheme_q == SchPprio) begin
              state_d = StVictim;
            end else begin
              state_d = StInsRead;
            end
          end
          ActFinish: state_d = csel_ok ? StStats : StDone;
          ActQuantum: begin
            if (!csel_ok || qcnt_q == '0) state_d = StDone;
            else state_d = StDeqRead;
          end
          default: state_d = StDone;
        endcase
      end
      StVictim: if (last_core) state_d = StInsRead;
      StInsRead: begin
        if (qcnt_q >= QCntW'(QueueDepth)) state_d = StDone;
        else if (qcnt_q == '0) state_d = StInsWrite;
        else state_d = StInsScan;
      end
      StInsScan: begin
        if (ranks_before(scheme_q, hold_q, ram_rd)) state_d = StShRead;
        else if (pos_q + 1'b1 >= qcnt_q) state_d = StInsWrite;
        else state_d = StInsScan;
      end
      StShRead: state_d = StShWrite;
      StShWrite: state_d = (pos_q == slot_q) ? StInsWrite : StShRead;
      StInsWrite: state_d = StDone;
      StStats: if (st_q == 2'd3) state_d = (qcnt_q == '0) ? StDone : StDeqRead;
      StDeqRead: state_d = StDeqHead;
      StDeqHead: begin
        if (head_loses) begin
          state_d = StDone;
        end else if (qcnt_q == QCntW'(1)) begin
          state_d = (act_q == ActQuantum) ? StInsRead : StDone;
        end else begin
          state_d = StDnRead;
        end
      end
      StDnRead: state_d = StDnWrite;
      StDnWrite: begin
        if (pos_q >= qcnt_q) begin
          state_d = (act_q == ActQuantum) ? StInsRead : StDone;
        end else begin
          state_d = StDnRead;
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    job_t rec;
    busy_d = busy_q;
    nj_d = nj_q;
    hold_d = hold_q;
    qcnt_d = qcnt_q;
    pos_d = pos_q;
    slot_d = slot_q;
    ci_d = ci_q;
    tgt_d = tgt_q;
    vic_d = vic_q;
    st_d = st_q;
    assigned_d = assigned_q;
    ovf_d = ovf_q;
    cout_d = cout_q;
    jout_d = jout_q;
    core_we = 1'b0;
    core_wa = ci_q[CoreW-1:0];
    core_wd = cj;
    ram_we = 1'b0;
    ram_a = pos_q[QIdxW-1:0];
    ram_wd = hold_q;
    stat_en = 1'b0;
    rec = cj;
    case (state_q)
      StIdle: begin
        ci_d = '0;
        pos_d = '0;
        st_d = '0;
        vic_d = 1'b0;
        assigned_d = 1'b0;
        ovf_d = 1'b0;
        cout_d = '0;
        jout_d = '0;
        nj_d.id = job_id_i;
        nj_d.prio = job_priority_i;
        nj_d.arrival = event_time_i;
        nj_d.start = event_time_i;
        nj_d.started = 1'b1;
        nj_d.length = run_length_i;
        nj_d.remain = {16'd0, run_length_i};
        hold_d = nj_d;
        hold_d.start = '0;
        hold_d.started = 1'b0;
      end
      StCount: begin
        if (busy_q[ci_q[CoreW-1:0]] && !back_q) begin
          rec.remain = (cj.remain > delta_q) ? cj.remain - delta_q : '0;
          core_we = 1'b1;
          core_wd = rec;
        end
        ci_d = ci_q + 1'b1;
        if (last_core) ci_d = '0;
      end
      StDispatch: begin
        if (act_q == ActArrive && idle_found) begin
          core_we = 1'b1;
          core_wa = idle_core;
          core_wd = nj_q;
          busy_d[idle_core] = 1'b1;
          assigned_d = 1'b1;
          cout_d = idle_core;
          jout_d = nj_q.id;
        end else if (act_q == ActQuantum && csel_ok) begin
          assigned_d = 1'b1;
          cout_d = csel_q;
          jout_d = core_job_q[csel_q].id;
        end
      end
      StVictim: begin
        if (ranks_before(scheme_q, vic_q ? core_job_q[tgt_q] : nj_q, cj)) begin
          vic_d = 1'b1;
          tgt_d = ci_q[CoreW-1:0];
        end
        ci_d = ci_q + 1'b1;
        if (last_core && vic_d) begin
          rec = core_job_q[tgt_d];
          // A job displaced at the instant it started has not really run.
          if (rec.started && rec.start == t_q) rec.started = 1'b0;
          hold_d = rec;
          core_we = 1'b1;
          core_wa = tgt_d;
          core_wd = nj_q;
          assigned_d = 1'b1;
          cout_d = tgt_d;
          jout_d = nj_q.id;
        end
      end
      StInsRead: begin
        ram_a = '0;
        pos_d = '0;
        if (qcnt_q >= QCntW'(QueueDepth)) ovf_d = 1'b1;
      end
      StInsScan: begin
        if (ranks_before(scheme_q, hold_q, ram_rd)) begin
          // Found the slot; move entries up one place from the tail downward.
          slot_d = pos_q;
          pos_d = qcnt_q - 1'b1;
        end else begin
          pos_d = pos_q + 1'b1;
          ram_a = QIdxW'(pos_q + 1'b1);
        end
      end
      StShRead: begin
        ram_a = QIdxW'(pos_q);
      end
      StShWrite: begin
        ram_we = 1'b1;
        ram_a = QIdxW'(pos_q + 1'b1);
        ram_wd = ram_rd;
        if (pos_q != slot_q) pos_d = pos_q - 1'b1;
      end
      StInsWrite: begin
        ram_we = 1'b1;
        ram_a = QIdxW'(pos_q);
        ram_wd = hold_q;
        qcnt_d = qcnt_q + 1'b1;
      end
      StStats: begin
        stat_en = 1'b1;
        st_d = st_q + 1'b1;
        if (st_q == 2'd3) begin
          busy_d[csel_q] = 1'b0;
        end
      end
      StDeqRead: begin
        ram_a = '0;
      end
      StDeqHead: begin
        if (!head_loses) begin
          rec = ram_rd;
          if (!rec.started) begin
            rec.start = t_q;
            rec.started = 1'b1;
          end
          hold_d = core_job_q[csel_q];
          core_we = 1'b1;
          core_wa = csel_q;
          core_wd = rec;
          busy_d[csel_q] = 1'b1;
          assigned_d = 1'b1;
          cout_d = csel_q;
          jout_d = rec.id;
          qcnt_d = qcnt_q - 1'b1;
          pos_d = QCntW'(1);
        end
      end
      StDnRead: begin
        ram_a = QIdxW'(pos_q);
      end
      StDnWrite: begin
        ram_we = 1'b1;
        ram_a = QIdxW'(pos_q - 1'b1);
        ram_wd = ram_rd;
        pos_d = pos_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign busy = (state_q != StIdle);
  assign done_o = done_q;
  assign assigned_o = assigned_q && done_q;
  assign core_out_o = done_q ? cout_q : '0;
  assign job_out_o = done_q ? jout_q : '0;
  assign queue_overflow_o = ovf_q && done_q;

  always_ff @(posedge clk_i) begin
    if (core_we) core_job_q[core_wa] <= core_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      scheme_q <= SchFcfs;
      cores_q <= ActW'(1);
      busy_q <= '0;
      qcnt_q <= '0;
      last_q <= '0;
      done_q <= 1'b0;
      act_q <= 2'd0;
      t_q <= '0;
      delta_q <= '0;
      back_q <= 1'b0;
      csel_q <= '0;
      nj_q <= '0;
      hold_q <= '0;
      pos_q <= '0;
      slot_q <= '0;
      ci_q <= '0;
      tgt_q <= '0;
      vic_q <= 1'b0;
      st_q <= '0;
      assigned_q <= 1'b0;
      ovf_q <= 1'b0;
      cout_q <= '0;
      jout_q <= '0;
    end else begin
      state_q <= state_d;
      busy_q <= busy_d;
      qcnt_q <= qcnt_d;
      done_q <= (state_q == StDone);
      nj_q <= nj_d;
      hold_q <= hold_d;
      pos_q <= pos_d;
      slot_q <= slot_d;
      ci_q <= ci_d;
      tgt_q <= tgt_d;
      vic_q <= vic_d;
      st_q <= st_d;
      assigned_q <= assigned_d;
      ovf_q <= ovf_d;
      cout_q <= cout_d;
      jout_q <= jout_d;
      if (cfg_wr && paddr[2] == RegScheme) scheme_q <= pwdata[2:0];
      if (cfg_wr && paddr[2] == RegCores) cores_q <= pwdata[ActW-1:0];
      if (state_q == StIdle && start) begin
        act_q <= action_i;
        t_q <= event_time_i;
        csel_q <= core_sel_i[CoreW-1:0];
        back_q <= (event_time_i < last_q);
        delta_q <= event_time_i - last_q;
        if (action_i != ActNone) last_q <= event_time_i;
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_ALWAYS(a_qcnt_bound, qcnt_q <= QCntW'(QueueDepth), "queue count beyond depth")
  `ASSERT_NEXT(a_done_pulse, done_q, !done_q, "result strobe longer than one cycle")
  `ASSERT_NEXT(a_start_busy, state_q == StIdle && start, busy, "accepted event did not raise busy")
endmodule

// ----- hw/rtl/mjs_ram.sv -----
// Generic single-port RAM with registered read.
module mjs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- hw/rtl/mjs_stats.sv -----
// Saturating statistic accumulators, updated one term per cycle while enabled.
module mjs_stats (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [1:0]  sel_i,
  input  logic [33:0] term_i,
  output logic [47:0] wait_o,
  output logic [47:0] turn_o,
  output logic [47:0] resp_o,
  output logic [31:0] done_o
);
  import mjs_pkg::*;

  logic [47:0] wait_q, wait_d, turn_q, turn_d, resp_q, resp_d;
  logic [31:0] done_q, done_d;
  logic [47:0] acc;
  logic [48:0] sum;

  // The term is a signed 34-bit difference; negative terms add nothing.
  always_comb begin
    acc = wait_q;
    if (sel_i == 2'd1) begin
      acc = turn_q;
    end else if (sel_i == 2'd2) begin
      acc = resp_q;
    end
    sum = {1'b0, acc} + {15'd0, term_i};
    wait_d = wait_q;
    turn_d = turn_q;
    resp_d = resp_q;
    done_d = done_q;
    if (en_i && !term_i[33]) begin
      case (sel_i)
        2'd0: wait_d = sum[48] ? SumMax : sum[47:0];
        2'd1: turn_d = sum[48] ? SumMax : sum[47:0];
        2'd2: resp_d = sum[48] ? SumMax : sum[47:0];
        default: done_d = (done_q == 32'hFFFF_FFFF) ? done_q : done_q + 32'd1;
      endcase
    end else if (en_i && sel_i == 2'd3) begin
      done_d = (done_q == 32'hFFFF_FFFF) ? done_q : done_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= '0;
      turn_q <= '0;
      resp_q <= '0;
      done_q <= '0;
    end else begin
      wait_q <= wait_d;
      turn_q <= turn_d;
      resp_q <= resp_d;
      done_q <= done_d;
    end
  end

  assign wait_o = wait_q;
  assign turn_o = turn_q;
  assign resp_o = resp_q;
  assign done_o = done_q;
endmodule

// ----- tb/sv/multicore_job_scheduler_core_test.sv -----
// Self-checking testbench of the job scheduler core: directed table, then random event streams.
`timescale 1ns / 100ps

module multicore_job_scheduler_core_test;
  import mjs_pkg::*;

  typedef struct {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [31:0] arrival;
    logic [31:0] begun_at;
    logic        begun;
    logic [31:0] remain;
    logic [15:0] length;
  } sched_job_t;

  typedef struct packed {
    logic        assigned;
    logic [2:0]  core;
    logic [15:0] job;
    logic        ovf;
    logic [47:0] wait_sum;
    logic [47:0] turn_sum;
    logic [47:0] resp_sum;
    logic [31:0] done_cnt;
  } outcome_t;

  typedef struct {
    action_e     act;
    logic [15:0] id;
    logic [31:0] t;
    logic [15:0] len;
    logic [7:0]  prio;
    logic [2:0]  core;
    bit          typed;
    outcome_t    want;
  } event_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [1:0]  action_i;
  logic [15:0] job_id_i;
  logic [31:0] event_time_i;
  logic [15:0] run_length_i;
  logic [7:0]  job_priority_i;
  logic [2:0]  core_sel_i;
  logic        done_o;
  logic        assigned_o;
  logic [2:0]  core_out_o;
  logic [15:0] job_out_o;
  logic        queue_overflow_o;
  logic [47:0] wait_total_o;
  logic [47:0] turnaround_total_o;
  logic [47:0] response_total_o;
  logic [31:0] jobs_done_o;

  multicore_job_scheduler_core i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .action_i, .job_id_i, .event_time_i, .run_length_i, .job_priority_i,
    .core_sel_i, .done_o, .assigned_o, .core_out_o, .job_out_o, .queue_overflow_o,
    .wait_total_o, .turnaround_total_o, .response_total_o, .jobs_done_o
  );

  // Scheduler mirror.
  logic [2:0]  sch_mode;
  logic [3:0]  core_setting;
  logic        core_busy_m [NumCores];
  sched_job_t  core_rec [NumCores];
  sched_job_t  ready_m [QueueDepth];
  int unsigned ready_cnt;
  logic [31:0] last_t;
  logic [47:0] wait_acc, turn_acc, resp_acc;
  logic [31:0] done_acc;

  outcome_t    outcome_q [$];
  int unsigned mismatches;
  bit          gaps_on;
  logic [31:0] now_t;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("multicore_job_scheduler_core_test failed");
    $finish;
  end

  function automatic bit ranks_ahead(sched_job_t a, sched_job_t b);
    logic [31:0] ka, kb;
    ka = a.arrival;
    kb = b.arrival;
    if (sch_mode == SchRr) return 1'b0;
    if (sch_mode == SchSjf || sch_mode == SchPsjf) begin
      ka = a.remain;
      kb = b.remain;
    end else if (sch_mode == SchPrio || sch_mode == SchPprio) begin
      ka = {24'd0, a.prio};
      kb = {24'd0, b.prio};
    end
    if (ka != kb) return ka < kb;
    return a.arrival < b.arrival;
  endfunction

  function automatic bit queue_insert(sched_job_t j);
    int unsigned pos;
    pos = 0;
    if (ready_cnt >= QueueDepth) return 1'b0;
    while (pos < ready_cnt && !ranks_ahead(j, ready_m[pos])) pos++;
    for (int k = ready_cnt; k > pos; k--) ready_m[k] = ready_m[k-1];
    ready_m[pos] = j;
    ready_cnt++;
    return 1'b1;
  endfunction

  function automatic sched_job_t queue_pop();
    sched_job_t h;
    h = ready_m[0];
    ready_cnt--;
    for (int k = 0; k < ready_cnt; k++) ready_m[k] = ready_m[k+1];
    return h;
  endfunction

  function automatic logic [47:0] sat_sum(logic [47:0] s, longint term);
    logic [63:0] v;
    if (term <= 0) return s;
    v = {16'd0, s} + 64'(term);
    if (v > {16'd0, SumMax}) return SumMax;
    return v[47:0];
  endfunction

  function automatic int active_count();
    if (core_setting < 1) return 1;
    if (core_setting > NumCores) return NumCores;
    return core_setting;
  endfunction

  function automatic outcome_t schedule_event(event_row_t e);
    outcome_t   r;
    int         n, idle, victim;
    sched_job_t nj, worst, hold, h, cur;
    logic [31:0] d;
    r = '0;
    n = active_count();
    if (e.act != ActNone) begin
      if (e.t >= last_t) begin
        d = e.t - last_t;
        for (int i = 0; i < n; i++)
          if (core_busy_m[i])
            core_rec[i].remain = core_rec[i].remain > d ? core_rec[i].remain - d : 32'd0;
      end
      last_t = e.t;
    end
    if (e.act == ActArrive) begin
      nj.id = e.id;
      nj.prio = e.prio;
      nj.arrival = e.t;
      nj.begun_at = 0;
      nj.begun = 1'b0;
      nj.length = e.len;
      nj.remain = {16'd0, e.len};
      idle = -1;
      for (int i = 0; i < n && idle < 0; i++) if (!core_busy_m[i]) idle = i;
      if (idle >= 0) begin
        nj.begun_at = e.t;
        nj.begun = 1'b1;
        core_rec[idle] = nj;
        core_busy_m[idle] = 1'b1;
        r.assigned = 1'b1;
        r.core = idle[2:0];
        r.job = nj.id;
      end else begin
        victim = -1;
        if (sch_mode == SchPsjf || sch_mode == SchPprio) begin
          worst = nj;
          for (int i = 0; i < n; i++)
            if (ranks_ahead(worst, core_rec[i])) begin
              victim = i;
              worst = core_rec[i];
            end
        end
        if (victim >= 0) begin
          hold = core_rec[victim];
          // A job displaced in the same instant it started has not really run.
          if (hold.begun && hold.begun_at == e.t) hold.begun = 1'b0;
          nj.begun_at = e.t;
          nj.begun = 1'b1;
          core_rec[victim] = nj;
          if (!queue_insert(hold)) r.ovf = 1'b1;
          r.assigned = 1'b1;
          r.core = victim[2:0];
          r.job = nj.id;
        end else if (!queue_insert(nj)) begin
          r.ovf = 1'b1;
        end
      end
    end else if (e.act == ActFinish) begin
      if (e.core < n && core_busy_m[e.core]) begin
        cur = core_rec[e.core];
        resp_acc = sat_sum(resp_acc, longint'(cur.begun_at) - longint'(cur.arrival));
        wait_acc = sat_sum(wait_acc, longint'(e.t) - longint'(cur.arrival)
                                     - longint'(cur.length));
        turn_acc = sat_sum(turn_acc, longint'(e.t) - longint'(cur.arrival));
        if (done_acc != 32'hFFFF_FFFF) done_acc++;
        core_busy_m[e.core] = 1'b0;
        if (ready_cnt > 0) begin
          h = queue_pop();
          if (!h.begun) begin
            h.begun_at = e.t;
            h.begun = 1'b1;
          end
          core_rec[e.core] = h;
          core_busy_m[e.core] = 1'b1;
          r.assigned = 1'b1;
          r.core = e.core;
          r.job = h.id;
        end
      end
    end else if (e.act == ActQuantum) begin
      if (e.core < n && core_busy_m[e.core]) begin
        if (ready_cnt > 0 && !ranks_ahead(core_rec[e.core], ready_m[0])) begin
          cur = core_rec[e.core];
          h = queue_pop();
          void'(queue_insert(cur));
          if (!h.begun) begin
            h.begun_at = e.t;
            h.begun = 1'b1;
          end
          core_rec[e.core] = h;
        end
        r.assigned = 1'b1;
        r.core = e.core;
        r.job = core_rec[e.core].id;
      end
    end
    r.wait_sum = wait_acc;
    r.turn_sum = turn_acc;
    r.resp_sum = resp_acc;
    r.done_cnt = done_acc;
    return r;
  endfunction

  // Results are strobed for one cycle; sample them mid-cycle.
  always @(negedge clk_i) begin
    outcome_t got, want;
    if (rst_ni && done_o) begin
      got = {assigned_o, core_out_o, job_out_o, queue_overflow_o, wait_total_o,
             turnaround_total_o, response_total_o, jobs_done_o};
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = outcome_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic reg_write(logic [0:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegScheme) sch_mode = val[2:0];
    else core_setting = val[3:0];
  endtask

  task automatic drain();
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Drives one request and records its expected result once it is taken.
  task automatic issue(event_row_t e);
    outcome_t want;
    if (gaps_on) while ($urandom_range(99) < 33) begin
      if (start) start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    action_i       <= e.act;
    job_id_i       <= e.id;
    event_time_i   <= e.t;
    run_length_i   <= e.len;
    job_priority_i <= e.prio;
    core_sel_i     <= e.core;
    do @(negedge clk_i); while (busy);
    want = schedule_event(e);
    if (e.typed && want !== e.want) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees: %p vs %p", e.want, want);
    end
    outcome_q.push_back(e.typed ? e.want : want);
    @(posedge clk_i);
  endtask

  function automatic event_row_t row(action_e a, logic [15:0] id, logic [31:0] t,
                                     logic [15:0] len, logic [7:0] pr, logic [2:0] c);
    event_row_t e;
    e.act = a; e.id = id; e.t = t; e.len = len; e.prio = pr; e.core = c;
    e.typed = 1'b0; e.want = '0;
    return e;
  endfunction

  function automatic event_row_t random_row(int n, bit fill);
    event_row_t e;
    int unsigned p;
    action_e a;
    p = $urandom_range(99);
    if (fill || p < 50) a = ActArrive;
    else if (p < 80) a = ActFinish;
    else if (p < 96) a = ActQuantum;
    else a = ActNone;
    case ($urandom_range(19))
      0: now_t = $urandom;
      1: now_t = now_t - $urandom_range(30);
      default: now_t = now_t + $urandom_range(40);
    endcase
    e = row(a, 16'($urandom), now_t, $urandom_range(9) == 0 ? 16'($urandom)
            : 16'($urandom_range(60)), 8'($urandom_range(3) == 0 ? $urandom
            : $urandom_range(7)), $urandom_range(9) == 0 ? 3'($urandom)
            : 3'($urandom_range(n - 1)));
    return e;
  endfunction

  initial begin
    event_row_t   dir_tab [$];
    event_row_t   e;
    logic [31:0]  modes [10][2];
    int           n;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; action_i = ActNone; job_id_i = '0; event_time_i = '0;
    run_length_i = '0; job_priority_i = '0; core_sel_i = '0;
    sch_mode = SchFcfs; core_setting = 4'd1; ready_cnt = 0; last_t = '0;
    wait_acc = '0; turn_acc = '0; resp_acc = '0; done_acc = '0; mismatches = 0;
    gaps_on = 1'b1; now_t = 32'd100;
    for (int i = 0; i < NumCores; i++) core_busy_m[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed events from reset: idle-core events, an unused code, extremes.
    e = row(ActFinish, 16'd0, 32'd0, 16'd0, 8'd0, 3'd0); e.typed = 1'b1; dir_tab.push_back(e);
    e = row(ActQuantum, 16'd0, 32'd0, 16'd0, 8'd0, 3'd0); e.typed = 1'b1; dir_tab.push_back(e);
    e = row(ActNone, 16'hFFFF, 32'd5, 16'hFFFF, 8'hFF, 3'd7); e.typed = 1'b1;
    dir_tab.push_back(e);
    e = row(ActArrive, 16'hFFFF, 32'd10, 16'hFFFF, 8'hFF, 3'd7); e.typed = 1'b1;
    e.want.assigned = 1'b1; e.want.job = 16'hFFFF; dir_tab.push_back(e);
    e = row(ActArrive, 16'h0000, 32'd10, 16'd0, 8'd0, 3'd0); e.typed = 1'b1;
    dir_tab.push_back(e);
    dir_tab.push_back(row(ActArrive, 16'h5555, 32'd12, 16'h00AA, 8'h55, 3'd2));
    dir_tab.push_back(row(ActQuantum, 16'd0, 32'd20, 16'd0, 8'd0, 3'd0));
    dir_tab.push_back(row(ActFinish, 16'd0, 32'd25, 16'd0, 8'd0, 3'd7));
    dir_tab.push_back(row(ActQuantum, 16'd0, 32'd26, 16'd0, 8'd0, 3'd5));
    dir_tab.push_back(row(ActFinish, 16'd0, 32'd30, 16'd0, 8'd0, 3'd0));
    dir_tab.push_back(row(ActFinish, 16'd0, 32'd40, 16'd0, 8'd0, 3'd0));
    dir_tab.push_back(row(ActArrive, 16'hAAAA, 32'hFFFF_FFFF, 16'h5555, 8'hAA, 3'd0));
    dir_tab.push_back(row(ActArrive, 16'h1234, 32'hFFFF_FFFF, 16'd3, 8'd1, 3'd0));
    dir_tab.push_back(row(ActQuantum, 16'd0, 32'd3, 16'd0, 8'd0, 3'd0));
    dir_tab.push_back(row(ActFinish, 16'd0, 32'd2, 16'd0, 8'd0, 3'd0));
    dir_tab.push_back(row(ActFinish, 16'd0, 32'hFFFF_FFFF, 16'd0, 8'd0, 3'd0));
    dir_tab.push_back(row(ActFinish, 16'd0, 32'hFFFF_FFFF, 16'd0, 8'd0, 3'd0));
    foreach (dir_tab[i]) issue(dir_tab[i]);
    start <= 1'b0;
    drain();

    modes = '{'{SchPsjf, 8}, '{SchPprio, 3}, '{SchPrio, 1}, '{SchSjf, 15},
              '{SchRr, 4}, '{SchFcfs, 0}, '{3'd7, 2}, '{SchPsjf, 1}, '{3'd6, 9},
              '{SchPprio, 8}};
    for (int ph = 0; ph < 10; ph++) begin
      reg_write(RegScheme, modes[ph][0]);
      reg_write(RegCores, modes[ph][1]);
      n = active_count();
      gaps_on = (ph != 3);
      // The single-core priority phase floods the queue past its depth.
      for (int k = 0; k < 45; k++) issue(random_row(n, ph == 2 && k < 40));
      if (start) start <= 1'b0;
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("multicore_job_scheduler_core_test passed");
    end else begin
      $display("multicore_job_scheduler_core_test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/mjs_pkg.sv
hw/rtl/mjs_ram.sv
hw/rtl/mjs_stats.sv
hw/rtl/multicore_job_scheduler_core.sv
tb/sv/multicore_job_scheduler_core_test.sv
